[rtl/sspu_pkg.sv]
// Shared widths, register indexes, reset values and types for the sprite projection unit.
package sspu_pkg;

	localparam int CoordW   = 16;
	localparam int DiffW    = 17;
	localparam int DistW    = 33;
	localparam int DimW     = 12;
	localparam int HalfW    = 11;
	localparam int BoundW   = 11;
	localparam int NumW     = 48;
	localparam int DenW     = 41;
	localparam int SumW     = 51;
	localparam int CfgIdxW  = 3;
	localparam int CfgDataW = 16;

	localparam int FrontStages = 5;
	localparam int BackStages  = 3;
	localparam int PipeDepth   = FrontStages + NumW + BackStages;

	localparam logic [CfgIdxW-1:0] RegPlayerX = 3'd0;
	localparam logic [CfgIdxW-1:0] RegPlayerY = 3'd1;
	localparam logic [CfgIdxW-1:0] RegDirX    = 3'd2;
	localparam logic [CfgIdxW-1:0] RegDirY    = 3'd3;
	localparam logic [CfgIdxW-1:0] RegPlaneX  = 3'd4;
	localparam logic [CfgIdxW-1:0] RegPlaneY  = 3'd5;
	localparam logic [CfgIdxW-1:0] RegWidth   = 3'd6;
	localparam logic [CfgIdxW-1:0] RegHeight  = 3'd7;

	localparam logic signed [CoordW-1:0] RstDirX   = 16'sd16384;
	localparam logic signed [CoordW-1:0] RstPlaneY = 16'sd10813;
	localparam logic [DimW-1:0]          RstWidth  = 12'd640;
	localparam logic [DimW-1:0]          RstHeight = 12'd480;

	typedef struct packed {
		logic             zero;
		logic             neg_d;
		logic             neg_c;
		logic [DistW-1:0] dsq;
	} side_t;

endpackage

[rtl/sspu_div.sv]
// Pipelined restoring divider, one quotient bit per stage, unsigned.
module sspu_div #(
	parameter int NW = 48,
	parameter int DW = 41
) (
	input  logic          clk,
	input  logic          en,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic [NW-1:0] quo
);

	logic [NW-1:0] nq_s  [NW];
	logic [DW-1:0] rem_s [NW-1];
	logic [DW-1:0] den_s [NW-1];

	for (genvar k = 0; k < NW; k++) begin : g_step
		logic [NW-1:0] nq_in;
		logic [DW-1:0] rem_in;
		logic [DW-1:0] den_in;
		logic [DW:0]   trial;
		logic [DW:0]   diff;

		if (k == 0) begin : g_first
			assign nq_in  = num;
			assign rem_in = '0;
			assign den_in = den;
		end else begin : g_next
			assign nq_in  = nq_s[k-1];
			assign rem_in = rem_s[k-1];
			assign den_in = den_s[k-1];
		end

		assign trial = {rem_in, nq_in[NW-1]};
		assign diff  = trial - {1'b0, den_in};

		always_ff @(posedge clk) begin
			if (en) begin
				nq_s[k] <= {nq_in[NW-2:0], ~diff[DW]};
			end
		end

		if (k < NW - 1) begin : g_carry
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[k] <= diff[DW] ? trial[DW-1:0] : diff[DW-1:0];
					den_s[k] <= den_in;
				end
			end
		end
	end

	assign quo = nq_s[NW-1];

endmodule

[rtl/sspu_dly.sv]
// Enabled delay line for side data that rides along the divider stages.
module sspu_dly #(
	parameter int W = 8,
	parameter int N = 4
) (
	input  logic         clk,
	input  logic         en,
	input  logic [W-1:0] din,
	output logic [W-1:0] dout
);

	logic [W-1:0] tap_s [N];

	always_ff @(posedge clk) begin
		if (en) begin
			tap_s[0] <= din;
			for (int i = 1; i < N; i++) begin
				tap_s[i] <= tap_s[i-1];
			end
		end
	end

	assign dout = tap_s[N-1];

endmodule

[rtl/sspu_front.sv]
// Front stages: offsets, camera products, sums, magnitudes and divider operands.
module sspu_front (
	input  logic                                clk,
	input  logic                                en,
	input  logic signed [sspu_pkg::CoordW-1:0]  sprite_x,
	input  logic signed [sspu_pkg::CoordW-1:0]  sprite_y,
	input  logic signed [sspu_pkg::CoordW-1:0]  player_x,
	input  logic signed [sspu_pkg::CoordW-1:0]  player_y,
	input  logic signed [sspu_pkg::CoordW-1:0]  dir_x,
	input  logic signed [sspu_pkg::CoordW-1:0]  dir_y,
	input  logic signed [sspu_pkg::CoordW-1:0]  plane_x,
	input  logic signed [sspu_pkg::CoordW-1:0]  plane_y,
	input  logic [sspu_pkg::HalfW-1:0]          half_w,
	input  logic [sspu_pkg::DimW-1:0]           screen_height,
	output logic [sspu_pkg::NumW-1:0]           num_d,
	output logic [sspu_pkg::DenW-1:0]           den_d,
	output logic [sspu_pkg::NumW-1:0]           num_c,
	output logic [sspu_pkg::DenW-1:0]           den_c,
	output logic [sspu_pkg::NumW-1:0]           num_s,
	output logic [sspu_pkg::DenW-1:0]           den_s,
	output sspu_pkg::side_t                     side
);

	logic signed [sspu_pkg::DiffW-1:0] cx_s1, cy_s1;

	logic signed [33:0] sqx_s2, sqy_s2, dycx_s2, dxcy_s2, plxcy_s2, plycx_s2;
	logic signed [31:0] plxdy_s2, dxply_s2;

	logic [33:0]        dist_s3;
	logic signed [33:0] nx_s3, ny_s3;
	logic signed [32:0] det_s3;

	logic signed [34:0] sum_c;
	logic [33:0]        dist_s4;
	logic [33:0]        mny_s4;
	logic [32:0]        mdet_s4;
	logic [34:0]        msum_s4;
	logic               zero_s4, negd_s4, negc_s4;

	logic [sspu_pkg::NumW-1:0] numd_s5, numc_s5, nums_s5;
	logic [sspu_pkg::DenW-1:0] dend_s5, denc_s5, dens_s5;
	sspu_pkg::side_t           side_s5;

	assign sum_c = 35'(nx_s3) + 35'(ny_s3);

	always_ff @(posedge clk) begin
		if (en) begin
			cx_s1 <= 17'(sprite_x) - 17'(player_x);
			cy_s1 <= 17'(sprite_y) - 17'(player_y);

			sqx_s2   <= cx_s1 * cx_s1;
			sqy_s2   <= cy_s1 * cy_s1;
			dycx_s2  <= dir_y * cx_s1;
			dxcy_s2  <= dir_x * cy_s1;
			plxcy_s2 <= plane_x * cy_s1;
			plycx_s2 <= plane_y * cx_s1;
			plxdy_s2 <= plane_x * dir_y;
			dxply_s2 <= dir_x * plane_y;

			dist_s3 <= unsigned'(sqx_s2) + unsigned'(sqy_s2);
			nx_s3   <= dycx_s2 - dxcy_s2;
			ny_s3   <= plxcy_s2 - plycx_s2;
			det_s3  <= 33'(plxdy_s2) - 33'(dxply_s2);

			dist_s4 <= dist_s3;
			mny_s4  <= ny_s3[33] ? unsigned'(-ny_s3) : unsigned'(ny_s3);
			mdet_s4 <= det_s3[32] ? unsigned'(-det_s3) : unsigned'(det_s3);
			msum_s4 <= sum_c[34] ? unsigned'(-sum_c) : unsigned'(sum_c);
			zero_s4 <= (det_s3 == '0) || (ny_s3 == '0);
			negd_s4 <= ny_s3[33] ^ det_s3[32];
			negc_s4 <= ny_s3[33] ^ sum_c[34];

			numd_s5 <= {mny_s4, 14'b0};
			dend_s5 <= sspu_pkg::DenW'(mdet_s4);
			numc_s5 <= sspu_pkg::NumW'(half_w) * sspu_pkg::NumW'(msum_s4);
			denc_s5 <= sspu_pkg::DenW'(mny_s4);
			nums_s5 <= sspu_pkg::NumW'(screen_height) * sspu_pkg::NumW'(mdet_s4);
			dens_s5 <= sspu_pkg::DenW'({mny_s4, 6'b0});
			side_s5.zero  <= zero_s4;
			side_s5.neg_d <= negd_s4;
			side_s5.neg_c <= negc_s4;
			side_s5.dsq   <= dist_s4[sspu_pkg::DistW-1:0];
		end
	end

	assign num_d = numd_s5;
	assign den_d = dend_s5;
	assign num_c = numc_s5;
	assign den_c = denc_s5;
	assign num_s = nums_s5;
	assign den_s = dens_s5;
	assign side  = side_s5;

endmodule

[rtl/sspu_back.sv]
// Back stages: signed quotients, saturation, draw bounds and screen clamps.
module sspu_back (
	input  logic                                clk,
	input  logic                                en,
	input  logic [sspu_pkg::NumW-1:0]           quo_d,
	input  logic [sspu_pkg::NumW-1:0]           quo_c,
	input  logic [sspu_pkg::NumW-1:0]           quo_s,
	input  sspu_pkg::side_t                     side,
	input  logic [sspu_pkg::HalfW-1:0]          half_w,
	input  logic [sspu_pkg::HalfW-1:0]          half_h,
	input  logic [sspu_pkg::DimW-1:0]           screen_width,
	input  logic [sspu_pkg::DimW-1:0]           screen_height,
	output logic [sspu_pkg::DistW-1:0]          dist_sq,
	output logic signed [sspu_pkg::CoordW-1:0]  depth,
	output logic signed [sspu_pkg::CoordW-1:0]  screen_col,
	output logic [sspu_pkg::CoordW-1:0]         sprite_size,
	output logic [sspu_pkg::BoundW-1:0]         x_first,
	output logic [sspu_pkg::BoundW-1:0]         x_last,
	output logic [sspu_pkg::BoundW-1:0]         y_first,
	output logic [sspu_pkg::BoundW-1:0]         y_last,
	output logic                                visible
);

	localparam int SW = sspu_pkg::SumW;

	function automatic logic [sspu_pkg::BoundW-1:0] clip(input logic signed [SW-1:0] v);
		logic [sspu_pkg::BoundW-1:0] r;
		if (v < 0) begin
			r = '0;
		end else if (v > SW'(2047)) begin
			r = 11'd2047;
		end else begin
			r = v[sspu_pkg::BoundW-1:0];
		end
		return r;
	endfunction

	function automatic logic [sspu_pkg::BoundW-1:0] clip_end(
		input logic signed [SW-1:0] v,
		input logic [sspu_pkg::DimW-1:0] lim
	);
		logic signed [SW-1:0] l;
		logic signed [SW-1:0] e;
		l = signed'(SW'(lim));
		e = (v >= l) ? l - SW'(1) : v;
		return clip(e);
	endfunction

	logic signed [15:0] depth_s1, depth_s2, depth_s3;
	logic signed [49:0] col_s1;
	logic [47:0]        size_s1;
	logic [sspu_pkg::DistW-1:0] dist_s1, dist_s2, dist_s3;

	logic signed [SW-1:0] sx0_s2, sx1_s2, sy0_s2, sy1_s2;
	logic signed [15:0]   col_s2, col_s3;
	logic [15:0]          size_s2, size_s3;

	logic [sspu_pkg::BoundW-1:0] sx0_s3, sx1_s3, sy0_s3, sy1_s3;
	logic [46:0] hs;

	assign hs = size_s1[47:1];

	always_ff @(posedge clk) begin
		if (en) begin
			dist_s1 <= side.dsq;
			if (side.zero) begin
				depth_s1 <= '0;
				col_s1   <= 50'(half_w);
				size_s1  <= '0;
			end else begin
				if (side.neg_d) begin
					depth_s1 <= (quo_d > 48'd32768) ? 16'sh8000 : -signed'(quo_d[15:0]);
				end else begin
					depth_s1 <= (quo_d > 48'd32767) ? 16'sh7FFF : signed'(quo_d[15:0]);
				end
				col_s1  <= side.neg_c ? -signed'({2'b0, quo_c}) : signed'({2'b0, quo_c});
				size_s1 <= quo_s;
			end

			dist_s2  <= dist_s1;
			depth_s2 <= depth_s1;
			sy0_s2 <= signed'(SW'(half_h)) - signed'(SW'(hs));
			sy1_s2 <= signed'(SW'(half_h)) + signed'(SW'(hs));
			sx0_s2 <= SW'(col_s1) - signed'(SW'(hs));
			sx1_s2 <= SW'(col_s1) + signed'(SW'(hs));
			size_s2 <= (size_s1 > 48'd65535) ? 16'hFFFF : size_s1[15:0];
			if (col_s1 > 50'sd32767) begin
				col_s2 <= 16'sh7FFF;
			end else if (col_s1 < -50'sd32768) begin
				col_s2 <= 16'sh8000;
			end else begin
				col_s2 <= col_s1[15:0];
			end

			dist_s3  <= dist_s2;
			depth_s3 <= depth_s2;
			col_s3   <= col_s2;
			size_s3  <= size_s2;
			sx0_s3 <= clip(sx0_s2);
			sx1_s3 <= clip_end(sx1_s2, screen_width);
			sy0_s3 <= clip(sy0_s2);
			sy1_s3 <= clip_end(sy1_s2, screen_height);
		end
	end

	assign dist_sq     = dist_s3;
	assign depth       = depth_s3;
	assign screen_col  = col_s3;
	assign sprite_size = size_s3;
	assign x_first     = sx0_s3;
	assign x_last      = sx1_s3;
	assign y_first     = sy0_s3;
	assign y_last      = sy1_s3;
	assign visible     = depth_s3 > 16'sd0;

endmodule

[rtl/sprite_screen_projection_unit.sv]
// Sprite screen projection unit: top level with config registers and pipeline control.
// Projects one sprite map position per item into camera space and screen bounds.
// Input channel: in_valid/in_ready with sprite_x, sprite_y (signed Q8.8).
// Output channel: out_valid/out_ready with dist_sq, depth, screen_col, sprite_size,
// x_first/x_last/y_first/y_last and visible; one result item per input item.
// Config: cfg_we writes cfg_data into register cfg_idx (player, dir, plane,
// screen size) on the clock edge; write only while no item is in flight.
// Throughput: one item per cycle while the output is not stalled. Stages:
// 5 front stages, 48 divider stages (one quotient bit each), 3 back stages.
// The three divisions run side by side in their own pipelined dividers.
// Stall: when out_valid is high and out_ready low the whole pipeline holds,
// and in_ready drops in that same cycle; nothing is lost or repeated.
// Bubbles are carried as cleared valid bits.
// Reset (arst_n low): all valid bits clear, registers return to defaults:
// player at origin, dir (1,0), plane (0,0.66), screen 640 x 480.
module sprite_screen_projection_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic signed [sspu_pkg::CoordW-1:0]  sprite_x,
	input  logic signed [sspu_pkg::CoordW-1:0]  sprite_y,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [sspu_pkg::DistW-1:0]          dist_sq,
	output logic signed [sspu_pkg::CoordW-1:0]  depth,
	output logic signed [sspu_pkg::CoordW-1:0]  screen_col,
	output logic [sspu_pkg::CoordW-1:0]         sprite_size,
	output logic [sspu_pkg::BoundW-1:0]         x_first,
	output logic [sspu_pkg::BoundW-1:0]         x_last,
	output logic [sspu_pkg::BoundW-1:0]         y_first,
	output logic [sspu_pkg::BoundW-1:0]         y_last,
	output logic                                visible,
	input  logic                                cfg_we,
	input  logic [sspu_pkg::CfgIdxW-1:0]        cfg_idx,
	input  logic [sspu_pkg::CfgDataW-1:0]       cfg_data
);

	localparam int Depth = sspu_pkg::PipeDepth;

	logic signed [sspu_pkg::CoordW-1:0] player_x_q, player_y_q, dir_x_q, dir_y_q;
	logic signed [sspu_pkg::CoordW-1:0] plane_x_q, plane_y_q;
	logic [sspu_pkg::DimW-1:0]          width_q, height_q;
	logic [sspu_pkg::HalfW-1:0]         half_w, half_h;

	logic [Depth-1:0] vld_q;
	logic             adv;

	logic [sspu_pkg::NumW-1:0] num_d, num_c, num_s, quo_d, quo_c, quo_s;
	logic [sspu_pkg::DenW-1:0] den_d, den_c, den_s;
	sspu_pkg::side_t           side_f, side_b;

	assign adv       = ~vld_q[Depth-1] | out_ready;
	assign in_ready  = adv;
	assign out_valid = vld_q[Depth-1];
	assign half_w    = width_q[sspu_pkg::DimW-1:1];
	assign half_h    = height_q[sspu_pkg::DimW-1:1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			player_x_q <= '0;
			player_y_q <= '0;
			dir_x_q    <= sspu_pkg::RstDirX;
			dir_y_q    <= '0;
			plane_x_q  <= '0;
			plane_y_q  <= sspu_pkg::RstPlaneY;
			width_q    <= sspu_pkg::RstWidth;
			height_q   <= sspu_pkg::RstHeight;
		end else if (cfg_we) begin
			case (cfg_idx)
				sspu_pkg::RegPlayerX: player_x_q <= signed'(cfg_data);
				sspu_pkg::RegPlayerY: player_y_q <= signed'(cfg_data);
				sspu_pkg::RegDirX:    dir_x_q    <= signed'(cfg_data);
				sspu_pkg::RegDirY:    dir_y_q    <= signed'(cfg_data);
				sspu_pkg::RegPlaneX:  plane_x_q  <= signed'(cfg_data);
				sspu_pkg::RegPlaneY:  plane_y_q  <= signed'(cfg_data);
				sspu_pkg::RegWidth:   width_q    <= cfg_data[sspu_pkg::DimW-1:0];
				sspu_pkg::RegHeight:  height_q   <= cfg_data[sspu_pkg::DimW-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[Depth-2:0], in_valid};
		end
	end

	sspu_front u_front (
		.clk           (clk),
		.en            (adv),
		.sprite_x      (sprite_x),
		.sprite_y      (sprite_y),
		.player_x      (player_x_q),
		.player_y      (player_y_q),
		.dir_x         (dir_x_q),
		.dir_y         (dir_y_q),
		.plane_x       (plane_x_q),
		.plane_y       (plane_y_q),
		.half_w        (half_w),
		.screen_height (height_q),
		.num_d         (num_d),
		.den_d         (den_d),
		.num_c         (num_c),
		.den_c         (den_c),
		.num_s         (num_s),
		.den_s         (den_s),
		.side          (side_f)
	);

	sspu_div #(.NW(sspu_pkg::NumW), .DW(sspu_pkg::DenW)) u_div_depth (
		.clk (clk), .en (adv), .num (num_d), .den (den_d), .quo (quo_d)
	);

	sspu_div #(.NW(sspu_pkg::NumW), .DW(sspu_pkg::DenW)) u_div_col (
		.clk (clk), .en (adv), .num (num_c), .den (den_c), .quo (quo_c)
	);

	sspu_div #(.NW(sspu_pkg::NumW), .DW(sspu_pkg::DenW)) u_div_size (
		.clk (clk), .en (adv), .num (num_s), .den (den_s), .quo (quo_s)
	);

	sspu_dly #(.W($bits(sspu_pkg::side_t)), .N(sspu_pkg::NumW)) u_side_dly (
		.clk  (clk),
		.en   (adv),
		.din  (side_f),
		.dout (side_b)
	);

	sspu_back u_back (
		.clk           (clk),
		.en            (adv),
		.quo_d         (quo_d),
		.quo_c         (quo_c),
		.quo_s         (quo_s),
		.side          (side_b),
		.half_w        (half_w),
		.half_h        (half_h),
		.screen_width  (width_q),
		.screen_height (height_q),
		.dist_sq       (dist_sq),
		.depth         (depth),
		.screen_col    (screen_col),
		.sprite_size   (sprite_size),
		.x_first       (x_first),
		.x_last        (x_last),
		.y_first       (y_first),
		.y_last        (y_last),
		.visible       (visible)
	);

endmodule

[bench/tb_sprite_screen_projection_unit.sv]
// Testbench for the sprite screen projection unit: random and directed sprites, predicted and checked.
`timescale 1ns / 100ps

module tb_sprite_screen_projection_unit;

	localparam int  Latency   = sspu_pkg::PipeDepth;
	localparam int  HoldLen   = 400;
	localparam int  NumPhases = 16;
	localparam int  PhaseLen  = 106;
	localparam longint CycleLimit = 1000000;

	typedef struct {
		logic signed [sspu_pkg::CoordW-1:0] sx;
		logic signed [sspu_pkg::CoordW-1:0] sy;
	} sprite_t;

	typedef struct {
		logic [sspu_pkg::DistW-1:0]         dsq;
		logic signed [sspu_pkg::CoordW-1:0] dep;
		logic signed [sspu_pkg::CoordW-1:0] col;
		logic [sspu_pkg::CoordW-1:0]        size;
		logic [sspu_pkg::BoundW-1:0]        sx0;
		logic [sspu_pkg::BoundW-1:0]        sx1;
		logic [sspu_pkg::BoundW-1:0]        sy0;
		logic [sspu_pkg::BoundW-1:0]        sy1;
		logic                               vis;
	} proj_t;

	logic                                 clk;
	logic                                 arst_n;
	logic                                 in_valid;
	logic                                 in_ready;
	logic signed [sspu_pkg::CoordW-1:0]   sprite_x;
	logic signed [sspu_pkg::CoordW-1:0]   sprite_y;
	logic                                 out_valid;
	logic                                 out_ready;
	logic [sspu_pkg::DistW-1:0]           dist_sq;
	logic signed [sspu_pkg::CoordW-1:0]   depth;
	logic signed [sspu_pkg::CoordW-1:0]   screen_col;
	logic [sspu_pkg::CoordW-1:0]          sprite_size;
	logic [sspu_pkg::BoundW-1:0]          x_first;
	logic [sspu_pkg::BoundW-1:0]          x_last;
	logic [sspu_pkg::BoundW-1:0]          y_first;
	logic [sspu_pkg::BoundW-1:0]          y_last;
	logic                                 visible;
	logic                                 cfg_we;
	logic [sspu_pkg::CfgIdxW-1:0]         cfg_idx;
	logic [sspu_pkg::CfgDataW-1:0]        cfg_data;

	sprite_screen_projection_unit dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.sprite_x(sprite_x), .sprite_y(sprite_y),
		.out_valid(out_valid), .out_ready(out_ready),
		.dist_sq(dist_sq), .depth(depth), .screen_col(screen_col),
		.sprite_size(sprite_size),
		.x_first(x_first), .x_last(x_last),
		.y_first(y_first), .y_last(y_last),
		.visible(visible),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
	);

	// camera settings as the block holds them
	longint cam_px, cam_py, cam_dx, cam_dy, cam_plx, cam_ply, cam_w, cam_h;

	sprite_t sprite_q[$];
	proj_t   proj_q[$];
	int      errors = 0;
	int      n_items = 0;
	int      n_results = 0;
	int      n_visible = 0;
	int      send_gap = 0;
	int      recv_gap = 0;
	int      hold_left = 0;
	bit      hold_req = 0;
	bit      no_idle = 0;
	longint  cycles = 0;

	function automatic longint clampl(longint v, longint lo, longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	function automatic proj_t project(logic signed [sspu_pkg::CoordW-1:0] sx,
		logic signed [sspu_pkg::CoordW-1:0] sy);
		longint cx, cy, dsq, det, nx, ny, hw, hh, dep, col, sz, hs, x0, x1, y0, y1;
		proj_t r;
		cx = longint'(sx) - cam_px;
		cy = longint'(sy) - cam_py;
		dsq = cx * cx + cy * cy;
		det = cam_plx * cam_dy - cam_dx * cam_ply;
		nx = cam_dy * cx - cam_dx * cy;
		ny = cam_plx * cy - cam_ply * cx;
		hw = cam_w / 2;
		hh = cam_h / 2;
		if (det == 0 || ny == 0) begin
			dep = 0;
			col = hw;
			sz = 0;
		end else begin
			dep = clampl((ny * 16384) / det, -32768, 32767);
			col = (hw * (nx + ny)) / ny;
			sz = (cam_h * det) / (ny * 64);
			if (sz < 0) sz = -sz;
		end
		hs = sz / 2;
		y0 = hh - hs;
		if (y0 < 0) y0 = 0;
		y1 = hh + hs;
		if (y1 >= cam_h) y1 = cam_h - 1;
		x0 = col - hs;
		if (x0 < 0) x0 = 0;
		x1 = col + hs;
		if (x1 >= cam_w) x1 = cam_w - 1;
		r.dsq  = dsq[sspu_pkg::DistW-1:0];
		r.dep  = dep[sspu_pkg::CoordW-1:0];
		r.col  = 16'(clampl(col, -32768, 32767));
		r.size = 16'(clampl(sz, 0, 65535));
		r.sx0  = 11'(clampl(x0, 0, 2047));
		r.sx1  = 11'(clampl(x1, 0, 2047));
		r.sy0  = 11'(clampl(y0, 0, 2047));
		r.sy1  = 11'(clampl(y1, 0, 2047));
		r.vis  = dep > 0;
		return r;
	endfunction

	task automatic report(string what, longint got, longint want);
		$display("mismatch on result %0d: %s got %0d expected %0d", n_results, what, got, want);
		errors++;
	endtask

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CycleLimit) begin
			$display("timeout after %0d cycles", cycles);
			$display("sprite_screen_projection_unit test failed");
			$finish;
		end
	end

	// driver
	always @(posedge clk or negedge arst_n) begin
		logic nv;
		sprite_t it;
		if (!arst_n) begin
			in_valid <= 1'b0;
			sprite_x <= '0;
			sprite_y <= '0;
		end else begin
			nv = in_valid;
			if (in_valid && in_ready) begin
				proj_q.push_back(project(sprite_x, sprite_y));
				n_items++;
				nv = 1'b0;
			end
			if (!nv) begin
				if (send_gap > 0) begin
					send_gap--;
				end else if (sprite_q.size() > 0) begin
					it = sprite_q.pop_front();
					sprite_x <= it.sx;
					sprite_y <= it.sy;
					nv = 1'b1;
					send_gap = no_idle ? 0 : $urandom_range(0, 19);
				end
			end
			in_valid <= nv;
		end
	end

	// long receiver hold-off
	always @(posedge clk) begin
		if (hold_left > 0)
			hold_left <= hold_left - 1;
		else if (hold_req)
			hold_left <= HoldLen;
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		proj_t e;
		logic nr;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (proj_q.size() == 0) begin
					$display("result with no item outstanding");
					errors++;
				end else begin
					e = proj_q.pop_front();
					if (dist_sq !== e.dsq) report("dist_sq", dist_sq, e.dsq);
					if (depth !== e.dep) report("depth", depth, e.dep);
					if (screen_col !== e.col) report("screen_col", screen_col, e.col);
					if (sprite_size !== e.size) report("sprite_size", sprite_size, e.size);
					if (x_first !== e.sx0) report("x_first", x_first, e.sx0);
					if (x_last !== e.sx1) report("x_last", x_last, e.sx1);
					if (y_first !== e.sy0) report("y_first", y_first, e.sy0);
					if (y_last !== e.sy1) report("y_last", y_last, e.sy1);
					if (visible !== e.vis) report("visible", visible, e.vis);
					if (e.vis) n_visible++;
				end
				n_results++;
				recv_gap = no_idle ? 0 : $urandom_range(0, 19);
			end
			if (hold_left > 0) begin
				nr = 1'b0;
			end else if (recv_gap > 0) begin
				recv_gap--;
				nr = 1'b0;
			end else begin
				nr = 1'b1;
			end
			out_ready <= nr;
		end
	end

	task automatic wait_drained();
		@(negedge clk);
		while (sprite_q.size() != 0 || in_valid || proj_q.size() != 0)
			@(negedge clk);
		repeat (Latency + 4) @(posedge clk);
	endtask

	task automatic write_reg(logic [sspu_pkg::CfgIdxW-1:0] idx, longint val);
		@(posedge clk);
		cfg_we   <= 1'b1;
		cfg_idx  <= idx;
		cfg_data <= 16'(val);
		case (idx)
			sspu_pkg::RegPlayerX: cam_px  = longint'($signed(16'(val)));
			sspu_pkg::RegPlayerY: cam_py  = longint'($signed(16'(val)));
			sspu_pkg::RegDirX:    cam_dx  = longint'($signed(16'(val)));
			sspu_pkg::RegDirY:    cam_dy  = longint'($signed(16'(val)));
			sspu_pkg::RegPlaneX:  cam_plx = longint'($signed(16'(val)));
			sspu_pkg::RegPlaneY:  cam_ply = longint'($signed(16'(val)));
			sspu_pkg::RegWidth:   cam_w   = val & 12'hFFF;
			sspu_pkg::RegHeight:  cam_h   = val & 12'hFFF;
			default: ;
		endcase
	endtask

	function automatic longint rnd16();
		return longint'($signed(16'($urandom)));
	endfunction

	task automatic set_camera(int p);
		longint v[8];
		v[0] = rnd16();
		v[1] = rnd16();
		v[2] = rnd16();
		v[3] = rnd16();
		v[4] = rnd16();
		v[5] = rnd16();
		v[6] = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2048) : $urandom_range(1, 64);
		v[7] = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2048) : $urandom_range(1, 64);
		if (p % 3 == 0) begin
			// rotation-like camera so that depths and sizes look like a real view
			v[2] = $urandom_range(0, 1) ? 16384 : -16384;
			v[3] = longint'($urandom_range(0, 4096)) - 2048;
			v[4] = -v[3] / 2;
			v[5] = longint'($urandom_range(0, 21626)) - 10813;
		end
		case (p)
			1: begin
				v[4] = v[2];
				v[5] = v[3];
			end
			2: begin
				v = '{32767, 32767, 32767, 32767, 32767, 32767, 2048, 2048};
			end
			3: begin
				v = '{-32768, -32768, -32768, -32768, -32768, -32768, 1, 1};
			end
			4: begin
				v[2] = 32767; v[3] = 0; v[4] = 0; v[5] = -32768;
				v[6] = 2048; v[7] = 1;
			end
			5: begin
				v[6] = 1; v[7] = 2048;
			end
			default: ;
		endcase
		for (int i = 0; i < 8; i++)
			write_reg(i[sspu_pkg::CfgIdxW-1:0], v[i]);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic add_sprite(longint x, longint y);
		sprite_t it;
		it.sx = 16'(x);
		it.sy = 16'(y);
		sprite_q.push_back(it);
	endtask

	initial begin
		arst_n   = 1'b0;
		cfg_we   = 1'b0;
		cfg_idx  = '0;
		cfg_data = '0;
		cam_px = 0; cam_py = 0;
		cam_dx = sspu_pkg::RstDirX; cam_dy = 0;
		cam_plx = 0; cam_ply = sspu_pkg::RstPlaneY;
		cam_w = sspu_pkg::RstWidth; cam_h = sspu_pkg::RstHeight;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed sprites on the reset camera
		add_sprite(0, 0);
		add_sprite(512, 0);
		add_sprite(-512, 0);
		add_sprite(0, 512);
		add_sprite(256, 128);
		add_sprite(64, -300);
		add_sprite(1, 0);
		add_sprite(32767, 32767);
		add_sprite(-32768, -32768);
		add_sprite(32767, -32768);
		add_sprite(-32768, 32767);
		add_sprite(32767, 0);
		wait_drained();

		for (int p = 1; p <= NumPhases; p++) begin
			set_camera(p);
			@(negedge clk);
			// back-to-back sending in phases 4, 9 and 14, and in phase 6 during the long hold so the pipeline fills
			no_idle = (p % 5 == 4) || (p == 6);
			if (p == 6)
				hold_req <= 1'b1;
			for (int i = 0; i < PhaseLen; i++) begin
				if ($urandom_range(0, 1))
					add_sprite(rnd16(), rnd16());
				else
					add_sprite(cam_px + longint'($urandom_range(0, 4096)) - 2048,
						cam_py + longint'($urandom_range(0, 4096)) - 2048);
			end
			if (p == 6) begin
				while (hold_left == 0) @(negedge clk);
				hold_req <= 1'b0;
			end
			if (p == 3) begin
				// directed sprites with a singular camera from phase one already seen;
				// here the sprite sits right on the player
				add_sprite(cam_px, cam_py);
			end
			wait_drained();
		end

		repeat (Latency + 20) @(posedge clk);
		if (proj_q.size() != 0) begin
			$display("%0d results never arrived", proj_q.size());
			errors++;
		end
		$display("%0d sprites projected over %0d camera settings, %0d visible, %0d mismatches",
			n_items, NumPhases + 1, n_visible, errors);
		$display("covered singular and extreme cameras, screen sizes 1 to 2048, long output stall");
		if (errors == 0)
			$display("sprite_screen_projection_unit test passed");
		else
			$display("sprite_screen_projection_unit test failed");
		$finish;
	end

endmodule
